>>> design/line_follow_steering_top_assert.svh
// Assertion macros for the line follower steering block.
// Used by the port checker; no other dependencies.
`ifndef LINE_FOLLOW_STEERING_TOP_ASSERT_SVH
`define LINE_FOLLOW_STEERING_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define LFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also checks across reset
`define LFS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lfs_pkg.sv
// Shared types, register codes and velocity arithmetic for the line follower.
// No dependencies.
`timescale 1ns / 1ps

package lfs_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_BASE_VELOCITY     = 3'd0;
  localparam logic [2:0] REG_RIGHT_TRIM        = 3'd1;
  localparam logic [2:0] REG_DEVIATION         = 3'd2;
  localparam logic [2:0] REG_NOTCH             = 3'd3;
  localparam logic [2:0] REG_SENSOR_THRESHOLD  = 3'd4;
  localparam logic [2:0] REG_CHECKPOINT_TARGET = 3'd5;

  // Reset values of the registers
  localparam logic [7:0] BASE_VELOCITY_RST     = 8'd128;
  localparam logic [5:0] RIGHT_TRIM_RST        = 6'd0;
  localparam logic [6:0] DEVIATION_RST         = 7'd32;
  localparam logic [5:0] NOTCH_RST             = 6'd8;
  localparam logic [7:0] SENSOR_THRESHOLD_RST  = 8'd128;
  localparam logic [7:0] CHECKPOINT_TARGET_RST = 8'd1;

  // Sensor patterns, left sensor is the top bit
  localparam logic [2:0] PAT_CHECKPOINT  = 3'd0;
  localparam logic [2:0] PAT_LEFT_ONE    = 3'd1;
  localparam logic [2:0] PAT_INVALID     = 3'd2;
  localparam logic [2:0] PAT_LEFT_TWO    = 3'd3;
  localparam logic [2:0] PAT_RIGHT_ONE   = 3'd4;
  localparam logic [2:0] PAT_RECENTER_A  = 3'd5;
  localparam logic [2:0] PAT_RIGHT_TWO   = 3'd6;
  localparam logic [2:0] PAT_RECENTER_B  = 3'd7;

  typedef struct packed {
    logic [7:0] base_velocity;
    logic [5:0] right_trim;
    logic [6:0] deviation;
    logic [5:0] notch;
    logic [7:0] sensor_threshold;
    logic [7:0] checkpoint_target;
  } cfg_t;

  // Saturate a signed intermediate velocity to 0..255
  function automatic logic [7:0] sat8(input logic signed [9:0] v);
    logic [7:0] r;
    if (v < 10'sd0) r = 8'd0;
    else if (v > 10'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

  // Slow a wheel by amt, not below base - dev
  function automatic logic [7:0] step_down(input logic [7:0] cur, input logic [6:0] amt,
                                           input logic [7:0] base, input logic [6:0] dev);
    logic signed [9:0] lo;
    logic signed [9:0] v;
    lo = $signed({2'b00, base}) - $signed({3'b000, dev});
    v  = $signed({2'b00, cur}) - $signed({3'b000, amt});
    if (v < lo) v = lo;
    return sat8(v);
  endfunction

  // Speed a wheel up by amt, not above base + dev
  function automatic logic [7:0] step_up(input logic [7:0] cur, input logic [6:0] amt,
                                         input logic [7:0] base, input logic [6:0] dev);
    logic signed [9:0] hi;
    logic signed [9:0] v;
    hi = $signed({2'b00, base}) + $signed({3'b000, dev});
    v  = $signed({2'b00, cur}) + $signed({3'b000, amt});
    if (v > hi) v = hi;
    return sat8(v);
  endfunction

endpackage

>>> design/lfs_if.sv
// Request channel interfaces for sensor samples in and steering results out.
// No dependencies.
`timescale 1ns / 1ps

interface lfs_in_if;
  logic       valid;
  logic       ready;
  logic       begin_run;
  logic [7:0] left_sample;
  logic [7:0] middle_sample;
  logic [7:0] right_sample;

  modport source (output valid, begin_run, left_sample, middle_sample, right_sample,
                  input ready);
  modport sink   (input valid, begin_run, left_sample, middle_sample, right_sample,
                  output ready);
endinterface

interface lfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_velocity;
  logic [7:0] right_velocity;
  logic       checkpoint_hit;
  logic       checkpoint_edge;
  logic       run_done;

  modport source (output valid, left_velocity, right_velocity, checkpoint_hit,
                  checkpoint_edge, run_done, input ready);
  modport sink   (input valid, left_velocity, right_velocity, checkpoint_hit,
                  checkpoint_edge, run_done, output ready);
endinterface

>>> design/line_follow_steering_top.sv
// Line follower steering block: top level.
// Depends on lfs_pkg, lfs_if, lfs_cfg_regs and lfs_steer_core.
//
// Takes one set of three line-sensor samples per cycle while input ready is
// high and returns one steering result per set: each set waits in the input
// register, then goes through the pattern decode and velocity clamp into
// the result register. Input ready drops only when both registers are full
// and the result is not taken, so a stalled result costs no throughput
// until the output side backs up. Configuration registers are written with
// cfg_we, cfg_index and cfg_data and take effect on the next item; indexes
// past the last register are ignored.
`timescale 1ns / 1ps

module line_follow_steering_top import lfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  lfs_in_if.sink     in_ch,
  lfs_out_if.source  out_ch
);

  cfg_t cfg;

  lfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfs_steer_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

>>> design/lfs_cfg_regs.sv
// Configuration register file for the line follower.
// Depends on lfs_pkg.
`timescale 1ns / 1ps

module lfs_cfg_regs import lfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_velocity     <= BASE_VELOCITY_RST;
      cfg.right_trim        <= RIGHT_TRIM_RST;
      cfg.deviation         <= DEVIATION_RST;
      cfg.notch             <= NOTCH_RST;
      cfg.sensor_threshold  <= SENSOR_THRESHOLD_RST;
      cfg.checkpoint_target <= CHECKPOINT_TARGET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_VELOCITY:     cfg.base_velocity     <= cfg_data;
        REG_RIGHT_TRIM:        cfg.right_trim        <= cfg_data[5:0];
        REG_DEVIATION:         cfg.deviation         <= cfg_data[6:0];
        REG_NOTCH:             cfg.notch             <= cfg_data[5:0];
        REG_SENSOR_THRESHOLD:  cfg.sensor_threshold  <= cfg_data;
        REG_CHECKPOINT_TARGET: cfg.checkpoint_target <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> design/lfs_steer_core.sv
// Steering datapath: input register, pattern decode, velocity update and
// checkpoint count, result register. Depends on lfs_pkg and lfs_if.
`timescale 1ns / 1ps

module lfs_steer_core import lfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  lfs_in_if.sink    in_ch,
  lfs_out_if.source out_ch
);

  // Input register
  logic       s1_valid;
  logic       s1_begin;
  logic [7:0] s1_left;
  logic [7:0] s1_middle;
  logic [7:0] s1_right;

  // Steering state
  logic [7:0] left_speed;
  logic [7:0] right_speed;
  logic       checkpoint_latch;
  logic [7:0] remaining_checkpoints;

  // Result register
  logic       res_valid;
  logic [7:0] res_left;
  logic [7:0] res_right;
  logic       res_hit;
  logic       res_edge;
  logic       res_done;

  // Next values
  logic       advance;
  logic [8:0] base_right_sum;
  logic [7:0] base_right;
  logic [7:0] cur_left;
  logic [7:0] cur_right;
  logic [7:0] cur_remaining;
  logic       cur_latch;
  logic [2:0] pattern;
  logic [6:0] amt_one;
  logic [6:0] amt_two;
  logic [7:0] left_speed_next;
  logic [7:0] right_speed_next;
  logic       hit_next;
  logic       edge_next;
  logic [7:0] remaining_next;

  // Result stage moves when empty or taken; input stage follows it
  assign advance     = !res_valid || out_ch.ready;
  assign in_ch.ready = !s1_valid || advance;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_begin  <= in_ch.begin_run;
      s1_left   <= in_ch.left_sample;
      s1_middle <= in_ch.middle_sample;
      s1_right  <= in_ch.right_sample;
    end
  end

  // Apply begin-run reload ahead of the pattern
  always_comb begin
    base_right_sum = {1'b0, cfg.base_velocity} + {3'b000, cfg.right_trim};
    base_right     = base_right_sum[8] ? 8'hFF : base_right_sum[7:0];
    cur_left       = s1_begin ? cfg.base_velocity : left_speed;
    cur_right      = s1_begin ? base_right : right_speed;
    cur_remaining  = s1_begin ? cfg.checkpoint_target : remaining_checkpoints;
    cur_latch      = s1_begin ? 1'b0 : checkpoint_latch;
  end

  // Threshold the samples and steer on the pattern
  always_comb begin
    pattern = {s1_left < cfg.sensor_threshold,
               s1_middle < cfg.sensor_threshold,
               s1_right < cfg.sensor_threshold};
    amt_one = {1'b0, cfg.notch};
    amt_two = {cfg.notch, 1'b0};
    left_speed_next  = cur_left;
    right_speed_next = cur_right;
    hit_next         = 1'b0;
    case (pattern)
      PAT_CHECKPOINT: hit_next = 1'b1;
      PAT_LEFT_ONE: begin
        left_speed_next  = step_down(cur_left, amt_one, cfg.base_velocity, cfg.deviation);
        right_speed_next = step_up(cur_right, amt_one, cfg.base_velocity, cfg.deviation);
      end
      PAT_LEFT_TWO: begin
        left_speed_next  = step_down(cur_left, amt_two, cfg.base_velocity, cfg.deviation);
        right_speed_next = step_up(cur_right, amt_two, cfg.base_velocity, cfg.deviation);
      end
      PAT_RIGHT_ONE: begin
        left_speed_next  = step_up(cur_left, amt_one, cfg.base_velocity, cfg.deviation);
        right_speed_next = step_down(cur_right, amt_one, cfg.base_velocity, cfg.deviation);
      end
      PAT_RIGHT_TWO: begin
        left_speed_next  = step_up(cur_left, amt_two, cfg.base_velocity, cfg.deviation);
        right_speed_next = step_down(cur_right, amt_two, cfg.base_velocity, cfg.deviation);
      end
      PAT_RECENTER_A, PAT_RECENTER_B: begin
        left_speed_next  = cfg.base_velocity;
        right_speed_next = base_right;
      end
      PAT_INVALID: ;
      default: ;
    endcase
  end

  // Count down on a rising checkpoint, stop at zero
  always_comb begin
    edge_next      = hit_next && !cur_latch;
    remaining_next = cur_remaining;
    if (edge_next && (cur_remaining != 8'd0)) begin
      remaining_next = cur_remaining - 8'd1;
    end
  end

  // Advance state and the result register together
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid             <= 1'b0;
      left_speed            <= 8'd0;
      right_speed           <= 8'd0;
      checkpoint_latch      <= 1'b0;
      remaining_checkpoints <= 8'd0;
    end else if (advance) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        left_speed            <= left_speed_next;
        right_speed           <= right_speed_next;
        checkpoint_latch      <= hit_next;
        remaining_checkpoints <= remaining_next;
      end
    end
    if (advance && s1_valid) begin
      res_left  <= left_speed_next;
      res_right <= right_speed_next;
      res_hit   <= hit_next;
      res_edge  <= edge_next;
      res_done  <= (remaining_next == 8'd0);
    end
  end

  assign out_ch.valid           = res_valid;
  assign out_ch.left_velocity   = res_left;
  assign out_ch.right_velocity  = res_right;
  assign out_ch.checkpoint_hit  = res_hit;
  assign out_ch.checkpoint_edge = res_edge;
  assign out_ch.run_done        = res_done;

endmodule

>>> design/lfs_checker.sv
// Port-level checks for the line follower steering block, bound to the top.
// Depends on line_follow_steering_top_assert.svh.
`timescale 1ns / 1ps
`include "line_follow_steering_top_assert.svh"

module lfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] left_velocity,
  input logic [7:0] right_velocity,
  input logic       checkpoint_hit,
  input logic       checkpoint_edge
);

  // A stalled result keeps its velocities
  `LFS_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(left_velocity) && $stable(right_velocity), "stalled result changed")
  // An edge is only reported on a hit
  `LFS_ASSERT_NOW(a_edge_hit, clk, rst, out_valid && checkpoint_edge, checkpoint_hit, "edge without hit")
  // A stalled result keeps its checkpoint flags
  `LFS_ASSERT_NEXT(a_stall_flags, clk, rst, out_valid && !out_ready, $stable(checkpoint_hit) && $stable(checkpoint_edge), "stalled flags changed")
  // Reset empties the result register
  `LFS_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid, "result valid after reset")

endmodule

bind line_follow_steering_top lfs_checker u_lfs_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .left_velocity   (out_ch.left_velocity),
  .right_velocity  (out_ch.right_velocity),
  .checkpoint_hit  (out_ch.checkpoint_hit),
  .checkpoint_edge (out_ch.checkpoint_edge)
);

>>> tb/tb.sv
// Self-checking bench for line_follow_steering_top: steering, clamps and checkpoint counting.
// Depends on lfs_pkg and the lfs_in_if / lfs_out_if channel interfaces.
`timescale 1ns / 1ps

module tb;
  import lfs_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int NOTCH_PAIR = 2;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic       begin_run;
    logic [7:0] left_sample;
    logic [7:0] middle_sample;
    logic [7:0] right_sample;
  } sample_t;

  typedef struct packed {
    logic [7:0] left_velocity;
    logic [7:0] right_velocity;
    logic       checkpoint_hit;
    logic       checkpoint_edge;
    logic       run_done;
  } steer_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  lfs_in_if  in_ch ();
  lfs_out_if out_ch ();

  line_follow_steering_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Sample sets waiting to be sent, and steering results waiting to arrive
  sample_t sample_q[$];
  steer_t  steer_q[$];

  // Shadow of the block's registers and state
  cfg_t       cfg_shadow;
  logic [7:0] left_spd;
  logic [7:0] right_spd;
  logic       cp_latch;
  logic [7:0] cp_remaining;

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_off_len;
  int  quiet_cycles;
  int  mismatches;
  int  sets_sent;
  int  results_seen;
  int  edges_seen;
  int  done_seen;
  int  settings_used;
  logic sample_taken;

  // Clock, period 4 ns
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Slow a wheel, not below base - deviation
  function automatic logic [7:0] slow_wheel(input logic [7:0] cur, input int amt);
    int floor_v;
    int v;
    floor_v = int'(cfg_shadow.base_velocity) - int'(cfg_shadow.deviation);
    v = int'(cur) - amt;
    if (v < floor_v) v = floor_v;
    return clamp_byte(v);
  endfunction

  // Speed a wheel up, not above base + deviation
  function automatic logic [7:0] speed_wheel(input logic [7:0] cur, input int amt);
    int ceil_v;
    int v;
    ceil_v = int'(cfg_shadow.base_velocity) + int'(cfg_shadow.deviation);
    v = int'(cur) + amt;
    if (v > ceil_v) v = ceil_v;
    return clamp_byte(v);
  endfunction

  // Advance the shadow state by one sample set and return the steering result
  function automatic steer_t steer_predict(input sample_t s);
    steer_t     r;
    logic [7:0] thr;
    logic [7:0] base_right;
    logic [2:0] pat;
    int         step;
    thr = cfg_shadow.sensor_threshold;
    base_right = clamp_byte(int'(cfg_shadow.base_velocity) + int'(cfg_shadow.right_trim));
    r = '0;
    if (s.begin_run) begin
      left_spd = cfg_shadow.base_velocity;
      right_spd = base_right;
      cp_remaining = cfg_shadow.checkpoint_target;
      cp_latch = 1'b0;
    end
    pat = {s.left_sample < thr, s.middle_sample < thr, s.right_sample < thr};
    step = int'(cfg_shadow.notch);
    if (pat == PAT_LEFT_TWO || pat == PAT_RIGHT_TWO) step = NOTCH_PAIR * step;
    case (pat)
      PAT_CHECKPOINT: r.checkpoint_hit = 1'b1;
      PAT_LEFT_ONE, PAT_LEFT_TWO: begin
        left_spd = slow_wheel(left_spd, step);
        right_spd = speed_wheel(right_spd, step);
      end
      PAT_RIGHT_ONE, PAT_RIGHT_TWO: begin
        left_spd = speed_wheel(left_spd, step);
        right_spd = slow_wheel(right_spd, step);
      end
      PAT_RECENTER_A, PAT_RECENTER_B: begin
        left_spd = cfg_shadow.base_velocity;
        right_spd = base_right;
      end
      default: ;
    endcase
    // Count rising checkpoint edges down, never past zero
    r.checkpoint_edge = r.checkpoint_hit && !cp_latch;
    if (r.checkpoint_edge && cp_remaining != 8'd0) cp_remaining = cp_remaining - 8'd1;
    cp_latch = r.checkpoint_hit;
    r.left_velocity = left_spd;
    r.right_velocity = right_spd;
    r.run_done = (cp_remaining == 8'd0);
    return r;
  endfunction

  // Pick a sample that reads as background (below threshold) or as line
  function automatic logic [7:0] sensor_level(input logic background);
    logic [7:0] thr;
    thr = cfg_shadow.sensor_threshold;
    if (!background) return 8'($urandom_range(255, thr));
    if (thr == 8'd0) return 8'd0;
    return 8'($urandom_range(thr - 1, 0));
  endfunction

  function automatic sample_t make_sample(input logic b, input logic [2:0] pat);
    sample_t s;
    s.begin_run = b;
    s.left_sample = sensor_level(pat[2]);
    s.middle_sample = sensor_level(pat[1]);
    s.right_sample = sensor_level(pat[0]);
    return s;
  endfunction

  task automatic queue_raw(input logic b, input logic [7:0] l, input logic [7:0] m,
                           input logic [7:0] r);
    sample_t s;
    s.begin_run = b;
    s.left_sample = l;
    s.middle_sample = m;
    s.right_sample = r;
    sample_q.push_back(s);
  endtask

  task automatic queue_pattern(input logic b, input logic [2:0] pat, input int reps);
    repeat (reps) sample_q.push_back(make_sample(b, pat));
  endtask

  // Mostly laps: a begin, then steering with checkpoint streaks; some pure noise
  task automatic queue_laps(input int count);
    int      left_n;
    int      streak;
    sample_t s;
    left_n = count;
    while (left_n > 0) begin
      if ($urandom_range(9) == 0) begin
        s.begin_run = 1'($urandom_range(1));
        s.left_sample = 8'($urandom_range(255));
        s.middle_sample = 8'($urandom_range(255));
        s.right_sample = 8'($urandom_range(255));
        sample_q.push_back(s);
        left_n--;
      end else begin
        sample_q.push_back(make_sample(1'b1, 3'($urandom_range(7))));
        left_n--;
        repeat ($urandom_range(20, 3)) begin
          if ($urandom_range(4) == 0) begin
            streak = $urandom_range(3, 1);
            queue_pattern(1'b0, PAT_CHECKPOINT, streak);
            left_n -= streak;
          end else begin
            sample_q.push_back(make_sample(1'b0, 3'($urandom_range(7, 1))));
            left_n--;
          end
        end
      end
    end
  endtask

  // Wait until every queued set is sent and every result has come back
  task automatic drain();
    wait (sample_q.size() == 0 && steer_q.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_BASE_VELOCITY:     cfg_shadow.base_velocity = val;
      REG_RIGHT_TRIM:        cfg_shadow.right_trim = val[5:0];
      REG_DEVIATION:         cfg_shadow.deviation = val[6:0];
      REG_NOTCH:             cfg_shadow.notch = val[5:0];
      REG_SENSOR_THRESHOLD:  cfg_shadow.sensor_threshold = val;
      REG_CHECKPOINT_TARGET: cfg_shadow.checkpoint_target = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input int base, input int trim, input int dev, input int nch,
                               input int thr, input int target);
    write_reg(REG_BASE_VELOCITY, 8'(base));
    write_reg(REG_RIGHT_TRIM, 8'(trim));
    write_reg(REG_DEVIATION, 8'(dev));
    write_reg(REG_NOTCH, 8'(nch));
    write_reg(REG_SENSOR_THRESHOLD, 8'(thr));
    write_reg(REG_CHECKPOINT_TARGET, 8'(target));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic load_random_settings();
    load_settings($urandom_range(255), $urandom_range(63), $urandom_range(127),
                  $urandom_range(63), $urandom_range(215, 40), $urandom_range(6));
  endtask

  // Sender: hold an offered request until taken, otherwise offer or idle
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || sample_taken) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.begin_run <= sample_q[0].begin_run;
        in_ch.left_sample <= sample_q[0].left_sample;
        in_ch.middle_sample <= sample_q[0].middle_sample;
        in_ch.right_sample <= sample_q[0].right_sample;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_len > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_len = hold_off_len - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    sample_t s;
    steer_t  got;
    steer_t  want;
    if (rst) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        got.left_velocity = out_ch.left_velocity;
        got.right_velocity = out_ch.right_velocity;
        got.checkpoint_hit = out_ch.checkpoint_hit;
        got.checkpoint_edge = out_ch.checkpoint_edge;
        got.run_done = out_ch.run_done;
        results_seen++;
        if (got.checkpoint_edge === 1'b1) edges_seen++;
        if (got.run_done === 1'b1) done_seen++;
        if (steer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("t=%0t unexpected result: L=%0d R=%0d hit=%b edge=%b done=%b", $realtime,
                     got.left_velocity, got.right_velocity, got.checkpoint_hit,
                     got.checkpoint_edge, got.run_done);
        end else begin
          want = steer_q.pop_front();
          if (got.left_velocity !== want.left_velocity ||
              got.right_velocity !== want.right_velocity ||
              got.checkpoint_hit !== want.checkpoint_hit ||
              got.checkpoint_edge !== want.checkpoint_edge ||
              got.run_done !== want.run_done) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("t=%0t result %0d: expected L=%0d R=%0d hit=%b edge=%b done=%b, got L=%0d R=%0d hit=%b edge=%b done=%b",
                       $realtime, results_seen, want.left_velocity, want.right_velocity,
                       want.checkpoint_hit, want.checkpoint_edge, want.run_done,
                       got.left_velocity, got.right_velocity, got.checkpoint_hit,
                       got.checkpoint_edge, got.run_done);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        s.begin_run = in_ch.begin_run;
        s.left_sample = in_ch.left_sample;
        s.middle_sample = in_ch.middle_sample;
        s.right_sample = in_ch.right_sample;
        void'(sample_q.pop_front());
        steer_q.push_back(steer_predict(s));
        sets_sent++;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_BASE_VELOCITY;
    cfg_data = 8'd0;
    in_ch.valid = 1'b0;
    in_ch.begin_run = 1'b0;
    in_ch.left_sample = 8'd0;
    in_ch.middle_sample = 8'd0;
    in_ch.right_sample = 8'd0;
    out_ch.ready = 1'b0;
    quiet_cycles = 0;
    hold_off_len = 0;
    mismatches = 0;
    sets_sent = 0;
    results_seen = 0;
    edges_seen = 0;
    done_seen = 0;
    settings_used = 1;
    send_idle_pct = 32;
    recv_idle_pct = 82;
    cfg_shadow.base_velocity = BASE_VELOCITY_RST;
    cfg_shadow.right_trim = RIGHT_TRIM_RST;
    cfg_shadow.deviation = DEVIATION_RST;
    cfg_shadow.notch = NOTCH_RST;
    cfg_shadow.sensor_threshold = SENSOR_THRESHOLD_RST;
    cfg_shadow.checkpoint_target = CHECKPOINT_TARGET_RST;
    left_spd = 8'd0;
    right_spd = 8'd0;
    cp_latch = 1'b0;
    cp_remaining = 8'd0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset defaults, threshold boundaries, every pattern and clamp
    queue_raw(1'b0, 8'd255, 8'd255, 8'd255);   // checkpoint straight out of reset
    queue_raw(1'b0, 8'd128, 8'd128, 8'd127);   // sample at threshold reads as line
    queue_raw(1'b1, 8'd0, 8'd0, 8'd0);         // begin run, recenter
    queue_pattern(1'b0, PAT_LEFT_TWO, 3);      // walk left wheel into its floor
    queue_pattern(1'b0, PAT_RIGHT_TWO, 3);
    queue_pattern(1'b0, PAT_RIGHT_ONE, 5);     // right wheel into its floor
    queue_pattern(1'b0, PAT_LEFT_ONE, 2);
    queue_raw(1'b0, 8'd255, 8'd0, 8'd255);     // invalid pattern holds
    queue_raw(1'b0, 8'd0, 8'd255, 8'd0);       // recenter
    queue_pattern(1'b0, PAT_CHECKPOINT, 2);    // edge then held hit
    queue_pattern(1'b0, PAT_LEFT_ONE, 1);
    queue_pattern(1'b0, PAT_CHECKPOINT, 1);    // edge with the run already done
    queue_pattern(1'b1, PAT_CHECKPOINT, 1);    // begin on a checkpoint clears latch
    queue_pattern(1'b1, PAT_RIGHT_ONE, 1);
    queue_pattern(1'b0, PAT_RECENTER_B, 1);
    drain();

    // Extremes: floor below zero, target zero, wide swings
    load_settings(0, 63, 127, 63, 255, 0);
    queue_laps(200);
    drain();
    // Extremes: base plus trim past 255, largest target, narrow threshold
    load_settings(255, 63, 127, 63, 1, 255);
    queue_laps(200);
    drain();
    // Minimums: everything reads as line
    load_settings(0, 0, 0, 0, 0, 2);
    queue_laps(60);
    drain();

    // Swap the idle mix
    send_idle_pct = 82;
    recv_idle_pct = 32;
    load_random_settings();
    queue_laps(200);
    drain();
    load_random_settings();
    queue_laps(200);
    drain();

    // Full rate, with a long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_random_settings();
    hold_off_len = 60;
    queue_laps(200);
    drain();
    // Full rate, with the sender paused midway until all results are back
    load_random_settings();
    queue_laps(100);
    drain();
    queue_laps(100);
    drain();

    $display("Checked %0d steering results from %0d sample sets over %0d register settings;",
             results_seen, sets_sent, settings_used);
    $display("%0d checkpoint edges and %0d run-done results observed.", edges_seen, done_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
